### src/dfwd_pkg.sv
`default_nettype none
package dfwd_pkg;

	localparam int FAULT_TRANSITIONS = 4;
	localparam int CNT_W = $clog2(FAULT_TRANSITIONS + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FAULT_TRANSITIONS);
	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;
	localparam logic [31:0] WINDOW_RESET = 32'd60000;

	typedef struct packed {
		logic load;
		logic drop;
		logic apply;
		logic commit;
	} dfwd_cmd_t;

	typedef struct packed {
		logic head_old;
		logic shift_old;
		logic out_free;
	} dfwd_stat_t;

endpackage
`default_nettype wire

### src/dfwd_evt_if.sv
`default_nettype none
interface dfwd_evt_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic        door_open_in;
	logic [31:0] now_ms;

	modport source (output valid, output action, output door_open_in, output now_ms,
		input ready);
	modport sink (input valid, input action, input door_open_in, input now_ms,
		output ready);
endinterface
`default_nettype wire

### src/dfwd_res_if.sv
`default_nettype none
interface dfwd_res_if;
	logic valid;
	logic ready;
	logic state_known;
	logic door_open;
	logic flap_fault;

	modport source (output valid, output state_known, output door_open, output flap_fault,
		input ready);
	modport sink (input valid, input state_known, input door_open, input flap_fault,
		output ready);
endinterface
`default_nettype wire

### src/dfwd_ctrl.sv
`default_nettype none
module dfwd_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                evt_valid,
	output logic                     evt_ready,
	input  wire dfwd_pkg::dfwd_stat_t stat,
	output dfwd_pkg::dfwd_cmd_t      cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_PURGE
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign evt_ready = ready_q;

	always_comb begin
		cmd.load   = evt_valid && ready_q;
		cmd.drop   = (state_q == ST_PURGE) && stat.head_old;
		cmd.apply  = (state_q == ST_PURGE) && !stat.head_old && stat.shift_old;
		cmd.commit = (state_q == ST_PURGE) && !stat.head_old && !stat.shift_old &&
			stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (evt_valid && ready_q) begin
						state_q <= ST_PURGE;
						ready_q <= 1'b0;
					end
				end
				ST_PURGE: begin
					if (!stat.head_old && !stat.shift_old && stat.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### src/dfwd_dp.sv
`default_nettype none
module dfwd_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dfwd_pkg::dfwd_cmd_t cmd,
	output dfwd_pkg::dfwd_stat_t     stat,
	input  wire logic                action,
	input  wire logic                door_open_in,
	input  wire logic [31:0]         now_ms,
	input  wire logic [31:0]         window_ms,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     state_known,
	output logic                     door_open,
	output logic                     flap_fault
);

	localparam int N = dfwd_pkg::FAULT_TRANSITIONS;
	localparam int CW = dfwd_pkg::CNT_W;
	localparam int HEAD_NEXT = (N > 1) ? 1 : 0;

	// latched word
	logic        action_q;
	logic        open_in_q;
	logic [31:0] now_q;

	logic                known_q;
	logic                last_q;
	logic [CW-1:0]       held_q;
	logic [N-1:0][31:0]  times_q;

	logic                out_valid_q;
	logic                known_out_q;
	logic                open_out_q;
	logic                fault_out_q;

	logic [31:0]         head_age;
	logic [31:0]         next_age;
	logic                change;
	logic                known_nx;
	logic                last_nx;
	logic [CW-1:0]       held_nx;
	logic [N-1:0][31:0]  times_nx;

	assign head_age       = now_q - times_q[0];
	assign next_age       = now_q - times_q[HEAD_NEXT];
	assign stat.head_old  = (held_q != '0) && (head_age > window_ms);
	// full store shift would expose a stale head
	assign stat.shift_old = change && (held_q == dfwd_pkg::FULL_CNT) &&
		(next_age > window_ms);
	assign stat.out_free  = !out_valid_q || out_ready;

	always_comb begin
		change   = action_q && known_q && (open_in_q != last_q);
		known_nx = known_q || action_q;
		last_nx  = action_q ? open_in_q : last_q;
		held_nx  = held_q;
		times_nx = times_q;
		if (cmd.drop) begin
			for (int i = 0; i < N - 1; i++) begin
				times_nx[i] = times_q[i + 1];
			end
			held_nx = held_q - CW'(1);
		end else if (change) begin
			if (held_q == dfwd_pkg::FULL_CNT) begin
				for (int i = 0; i < N - 1; i++) begin
					times_nx[i] = times_q[i + 1];
				end
				times_nx[N - 1] = now_q;
			end else begin
				for (int i = 0; i < N; i++) begin
					if (held_q == CW'(i)) begin
						times_nx[i] = now_q;
					end
				end
				held_nx = held_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q  <= action;
			open_in_q <= door_open_in;
			now_q     <= now_ms;
		end else if (cmd.apply) begin
			action_q  <= 1'b0;
		end
		if (cmd.drop || cmd.apply || cmd.commit) begin
			times_q <= times_nx;
		end
		if (cmd.commit) begin
			known_out_q <= known_nx;
			open_out_q  <= known_nx && last_nx;
			fault_out_q <= (held_nx == dfwd_pkg::FULL_CNT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q     <= 1'b0;
			last_q      <= 1'b0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.drop) begin
				held_q <= held_nx;
			end else if (cmd.commit || cmd.apply) begin
				held_q  <= held_nx;
				known_q <= known_nx;
				last_q  <= last_nx;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign state_known = known_out_q;
	assign door_open   = open_out_q;
	assign flap_fault  = fault_out_q;

endmodule
`default_nettype wire

### src/door_flap_window_detector.sv
`default_nettype none
// Door flap detector over a sliding time window. Each word on evt carries a
// millisecond time stamp and, for a door sample, the reported open flag; each
// word gives exactly one result word on res with the known flag, the door state
// and a flap fault, set when FAULT_TRANSITIONS transitions lie within window_ms
// (APB register at byte 0, reset 60000). After a word is taken, each stored
// transition that has aged out of the window is dropped (0 to FAULT_TRANSITIONS
// of them), and one more step is taken when a door change pushes the oldest
// time out of a full store and the time behind it is already stale: the purge
// loop retires one stored time per cycle through a 32-bit subtract and compare.
// One item is worked on at a time; a result waits in the output register while
// the next word is taken, and the update stalls only while that register is
// still full.
module door_flap_window_detector (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	dfwd_evt_if.sink                                 evt,
	dfwd_res_if.source                               res,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [dfwd_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [dfwd_pkg::APB_DATA_W-1:0]     pwdata,
	output logic      [dfwd_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                     pready
);

	logic [31:0]          window_q;
	dfwd_pkg::dfwd_cmd_t  cmd;
	dfwd_pkg::dfwd_stat_t stat;
	logic                 apb_wr;

	// only register sits at byte 0
	assign apb_wr = psel && penable && pwrite && pready && (paddr == '0);
	assign pready = 1'b1;
	assign prdata = window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= dfwd_pkg::WINDOW_RESET;
		end else if (apb_wr) begin
			window_q <= pwdata;
		end
	end

	dfwd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dfwd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.action       (evt.action),
		.door_open_in (evt.door_open_in),
		.now_ms       (evt.now_ms),
		.window_ms    (window_q),
		.out_valid    (res.valid),
		.out_ready    (res.ready),
		.state_known  (res.state_known),
		.door_open    (res.door_open),
		.flap_fault   (res.flap_fault)
	);

	// busy after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(evt.valid && evt.ready) |=> !evt.ready)
		else $error("word taken while previous item still in work");

	// commit always leaves a result
	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> res.valid)
		else $error("commit without result");

	// never purge and commit together, never take a word mid item
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.drop && cmd.commit) && !(cmd.load && (cmd.drop || cmd.commit)))
		else $error("conflicting datapath commands");

	// a result is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && res.valid) |-> res.ready)
		else $error("result overwritten");

endmodule
`default_nettype wire
